// ===== rtl/sli_pkg.sv =====
package sli_pkg;

    localparam int LIST_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ID_W       = 32;
    localparam int SCORE_W    = 32;
    localparam int FREQ_W     = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PROBE = 1'b1;

    // one stored first-list entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [FREQ_W-1:0]  freq;
    } entry_t;

    // saturating q16.16 add
    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
    endfunction

endpackage

// ===== rtl/sli_store.sv =====
module sli_store
    import sli_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [LIST_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_list_intersection_top.sv =====
// sorted list intersection, merge join of two posting lists
//
// input channel (s_*): one item per handshake. cmd = load appends an entry
// (doc_id, score, freq) of the first list to the entry store; new_list on a
// load empties the store and rewinds the walk pointer first. cmd = probe
// streams one entry of the second list, ascending by doc_id.
// result channel (m_*): one item per probe whose doc_id is found under the
// walk pointer: id, saturated score sum, both scores and the stored freq.
//
// throughput: a load, or a probe with the pointer at the end, is taken in
// idle and leaves s_ready high. any other probe enters the walk, which holds
// s_ready low while the pointer steps over stored entries; this is set by the
// single read port of the entry store (one entry read per cycle, registered).
// result path: the matched entry goes through the store read register, is
// compared in the walk state and is loaded into the result register.
// the result register frees the input side: new items are taken while a
// result still waits. if the receiver stalls and another match is found,
// the walk holds on that entry until the result register drains.
// reset: clears the entry count, the walk pointer and m_valid. the store
// itself is not cleared; only entries below the count are ever read.
module sorted_list_intersection_top
    import sli_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic               s_new_list,
    input  logic [ID_W-1:0]    s_doc_id,
    input  logic [SCORE_W-1:0] s_score,
    input  logic [FREQ_W-1:0]  s_freq,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [ID_W-1:0]    m_match_doc_id,
    output logic [SCORE_W-1:0] m_score_sum,
    output logic [SCORE_W-1:0] m_score_first,
    output logic [SCORE_W-1:0] m_score_second,
    output logic [FREQ_W-1:0]  m_match_freq
);

    // idle takes items, walk steps through the store for one probe
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;

    // probe under way
    logic [ID_W-1:0]    probe_id_reg;
    logic [SCORE_W-1:0] probe_score_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [SCORE_W-1:0] out_sum_reg;
    logic [SCORE_W-1:0] out_first_reg;
    logic [SCORE_W-1:0] out_second_reg;
    logic [FREQ_W-1:0]  out_freq_reg;
    logic               out_load;

    // store port signals
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;

    logic             in_fire;
    logic [CNT_W-1:0] ptr_inc;
    logic             out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    // result register can take a new item this cycle
    assign out_free = !out_valid_reg || m_ready;

    sli_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_data = '{id: s_doc_id, score: s_score, freq: s_freq};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[ADDR_W-1:0];
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_cmd == CMD_LOAD) begin
                        if (s_new_list) begin
                            // empty the store, entry goes to slot zero
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            count_next = CNT_W'(1);
                            ptr_next   = '0;
                        end else if (count_reg < CNT_W'(LIST_DEPTH)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (ptr_reg < count_reg) begin
                        // fetch the entry under the pointer
                        rd_en      = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (rd_data.id < probe_id_reg) begin
                    // step past a smaller id, fetch the next one if any
                    ptr_next = ptr_inc;
                    if (ptr_inc < count_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_inc[ADDR_W-1:0];
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (rd_data.id == probe_id_reg) begin
                    // match: wait here for room in the result register
                    if (out_free) begin
                        out_load   = 1'b1;
                        ptr_next   = ptr_inc;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            probe_id_reg    <= s_doc_id;
            probe_score_reg <= s_score;
        end
        if (out_load) begin
            out_id_reg     <= probe_id_reg;
            out_sum_reg    <= sat_add(rd_data.score, probe_score_reg);
            out_first_reg  <= rd_data.score;
            out_second_reg <= probe_score_reg;
            out_freq_reg   <= rd_data.freq;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_match_doc_id = out_id_reg;
    assign m_score_sum    = out_sum_reg;
    assign m_score_first  = out_first_reg;
    assign m_score_second = out_second_reg;
    assign m_match_freq   = out_freq_reg;

endmodule

// ===== rtl/sli_checker.sv =====
module sli_checker
    import sli_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ID_W-1:0]    m_match_doc_id,
    input logic [SCORE_W-1:0] m_score_sum,
    input logic [SCORE_W-1:0] m_score_first,
    input logic [SCORE_W-1:0] m_score_second
);

    logic [SCORE_W:0] raw_sum;

    assign raw_sum = {1'b0, m_score_first} + {1'b0, m_score_second};

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_match_doc_id) && $stable(m_score_sum))
        else $error("result changed while stalled");

    // sum agrees with the two scores, saturated
    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (raw_sum[SCORE_W] && m_score_sum == {SCORE_W{1'b1}})
                 || (!raw_sum[SCORE_W] && m_score_sum == raw_sum[SCORE_W-1:0]))
        else $error("score sum mismatch");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sorted_list_intersection_top sli_checker u_sli_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_match_doc_id (m_match_doc_id),
    .m_score_sum    (m_score_sum),
    .m_score_first  (m_score_first),
    .m_score_second (m_score_second)
);

// ===== verif/sli_match_checker.sv =====
module sli_match_checker
    import sli_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_cmd,
    input  logic               s_new_list,
    input  logic [ID_W-1:0]    s_doc_id,
    input  logic [SCORE_W-1:0] s_score,
    input  logic [FREQ_W-1:0]  s_freq,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [ID_W-1:0]    m_match_doc_id,
    input  logic [SCORE_W-1:0] m_score_sum,
    input  logic [SCORE_W-1:0] m_score_first,
    input  logic [SCORE_W-1:0] m_score_second,
    input  logic [FREQ_W-1:0]  m_match_freq,

    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0]    doc_id;
        logic [SCORE_W-1:0] sum;
        logic [SCORE_W-1:0] first;
        logic [SCORE_W-1:0] second;
        logic [FREQ_W-1:0]  freq;
    } match_t;

    // own copy of the first list and the merge position
    logic [ID_W-1:0]    list_ids    [LIST_DEPTH];
    logic [SCORE_W-1:0] list_scores [LIST_DEPTH];
    logic [FREQ_W-1:0]  list_freqs  [LIST_DEPTH];
    logic [CNT_W-1:0]   list_count;
    logic [CNT_W-1:0]   walk;

    match_t match_queue[$];

    // applies one accepted item, returns 1 when it yields a match
    function automatic bit intersect_item(input logic cmd, input logic new_list,
                                          input logic [ID_W-1:0] id,
                                          input logic [SCORE_W-1:0] score,
                                          input logic [FREQ_W-1:0] freq,
                                          output match_t m);
        logic [SCORE_W:0] total;
        m = '0;
        if (cmd == CMD_LOAD) begin
            if (new_list) begin
                list_count = '0;
                walk       = '0;
            end
            // full store drops the entry
            if (list_count < LIST_DEPTH) begin
                list_ids[list_count]    = id;
                list_scores[list_count] = score;
                list_freqs[list_count]  = freq;
                list_count              = list_count + 1'b1;
            end
            return 1'b0;
        end
        while (walk < list_count && list_ids[walk] < id)
            walk = walk + 1'b1;
        if (walk < list_count && list_ids[walk] == id) begin
            total    = {1'b0, list_scores[walk]} + {1'b0, score};
            m.doc_id = id;
            m.sum    = total[SCORE_W] ? {SCORE_W{1'b1}} : total[SCORE_W-1:0];
            m.first  = list_scores[walk];
            m.second = score;
            m.freq   = list_freqs[walk];
            walk     = walk + 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin : watch
        match_t got;
        match_t want;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            list_count = '0;
            walk       = '0;
            match_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (intersect_item(s_cmd, s_new_list, s_doc_id, s_score, s_freq, got))
                    match_queue.insert(match_queue.size(), got);
            end
            if (m_valid && m_ready) begin
                if (match_queue.size() == 0) begin
                    $error("unexpected result: match_doc_id %h score_sum %h",
                           m_match_doc_id, m_score_sum);
                    errs++;
                end else begin
                    want = match_queue.pop_front();
                    if (m_match_doc_id !== want.doc_id) begin
                        $error("match_doc_id expected %h actual %h", want.doc_id, m_match_doc_id);
                        errs++;
                    end
                    if (m_score_sum !== want.sum) begin
                        $error("score_sum expected %h actual %h", want.sum, m_score_sum);
                        errs++;
                    end
                    if (m_score_first !== want.first) begin
                        $error("score_first expected %h actual %h", want.first, m_score_first);
                        errs++;
                    end
                    if (m_score_second !== want.second) begin
                        $error("score_second expected %h actual %h", want.second,
                               m_score_second);
                        errs++;
                    end
                    if (m_match_freq !== want.freq) begin
                        $error("match_freq expected %h actual %h", want.freq, m_match_freq);
                        errs++;
                    end
                end
            end
        end
        fail_count <= fail_count + errs;
        pending    <= match_queue.size();
    end

endmodule

// ===== verif/sorted_list_intersection_top_tb.sv =====
module sorted_list_intersection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    // receiver hold-off length for the back-pressure phase
    localparam int HOLD_CYCLES   = 300;
    // cycles with no handshake on either channel before giving up
    localparam int IDLE_LIMIT    = 20000;
    // minimum number of random items per idling phase
    localparam int PHASE_ITEMS   = 420;
    // a missing probe may still walk the whole store after the last result
    localparam int SETTLE_CYCLES = LIST_DEPTH + 16;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;

    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_cmd          = CMD_LOAD;
    logic               s_new_list     = 1'b0;
    logic [ID_W-1:0]    s_doc_id       = '0;
    logic [SCORE_W-1:0] s_score        = '0;
    logic [FREQ_W-1:0]  s_freq         = '0;

    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [ID_W-1:0]    m_match_doc_id;
    logic [SCORE_W-1:0] m_score_sum;
    logic [SCORE_W-1:0] m_score_first;
    logic [SCORE_W-1:0] m_score_second;
    logic [FREQ_W-1:0]  m_match_freq;

    int fail_count;
    int pending;

    // idling knobs: sender one read only by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_count     = 0;

    // hold-off request: stimulus toggles, receiver acknowledges
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;
    int   quiet     = 0;

    sorted_list_intersection_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_new_list     (s_new_list),
        .s_doc_id       (s_doc_id),
        .s_score        (s_score),
        .s_freq         (s_freq),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_doc_id (m_match_doc_id),
        .m_score_sum    (m_score_sum),
        .m_score_first  (m_score_first),
        .m_score_second (m_score_second),
        .m_match_freq   (m_match_freq)
    );

    sli_match_checker u_match_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_new_list     (s_new_list),
        .s_doc_id       (s_doc_id),
        .s_score        (s_score),
        .s_freq         (s_freq),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_doc_id (m_match_doc_id),
        .m_score_sum    (m_score_sum),
        .m_score_first  (m_score_first),
        .m_score_second (m_score_second),
        .m_match_freq   (m_match_freq),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always #2 aclk = ~aclk;

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // offers one item, with random idle cycles ahead of it, and waits for acceptance
    task automatic send_item(input logic cmd, input logic new_list,
                             input logic [ID_W-1:0] id,
                             input logic [SCORE_W-1:0] score,
                             input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_new_list <= new_list;
        s_doc_id   <= id;
        s_score    <= score;
        s_freq     <= freq;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
    endtask

    // sender goes quiet until every predicted match has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // mix of small, near-saturating and arbitrary q16.16 scores
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(3))
            0:       return $urandom_range(0, 32'h0001_FFFF);
            1:       return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [ID_W-1:0] list_ids[$];
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] base;
        int              len;
        int              phase;
        int              target;
        int              r;
        int              k;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed items ----
        // probe on an empty store, pointer already at the end
        send_item(CMD_PROBE, 1'b0, 32'd12, 32'd1, 16'd0);
        // first list with extreme ids, scores and freqs, plus a duplicate id
        send_item(CMD_LOAD, 1'b1, 32'd0, 32'd0, 16'd0);
        send_item(CMD_LOAD, 1'b0, 32'd5, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_LOAD, 1'b0, 32'd5, 32'd1, 16'd1);
        send_item(CMD_LOAD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
        // lowest id, sum lands exactly on full scale
        send_item(CMD_PROBE, 1'b0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        // saturating sum on the first of the duplicates
        send_item(CMD_PROBE, 1'b0, 32'd5, 32'd1, 16'd0);
        // repeated probe id takes the next equal entry
        send_item(CMD_PROBE, 1'b0, 32'd5, 32'd0, 16'd0);
        // third probe of the same id finds no equal entry left
        send_item(CMD_PROBE, 1'b0, 32'd5, 32'h0001_0000, 16'd0);
        // out of order probe, pointer never moves back
        send_item(CMD_PROBE, 1'b0, 32'd3, 32'h0001_0000, 16'd0);
        // load while probing is appended, leaves the list unsorted
        send_item(CMD_LOAD, 1'b0, 32'd7, 32'h0000_8000, 16'd7);
        // top id, both scores at full scale
        send_item(CMD_PROBE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        // appended entry is walked as stored
        send_item(CMD_PROBE, 1'b1, 32'd7, 32'h0000_8000, 16'hFFFF);
        // pointer at end gives nothing
        send_item(CMD_PROBE, 1'b1, 32'd8, 32'd0, 16'd0);
        // new list restarts store and pointer, unsorted entries
        send_item(CMD_LOAD, 1'b1, 32'd100, 32'h0001_0000, 16'd3);
        send_item(CMD_LOAD, 1'b0, 32'd50, 32'h0002_0000, 16'd4);
        send_item(CMD_PROBE, 1'b0, 32'd60, 32'd9, 16'd0);
        send_item(CMD_PROBE, 1'b0, 32'd100, 32'd9, 16'd0);
        send_item(CMD_PROBE, 1'b0, 32'd50, 32'd9, 16'd0);
        wait_drained();

        // ---- back pressure: receiver holds off, sender keeps offering matches ----
        hold_req <= ~hold_req;
        base = $urandom;
        for (k = 0; k < 40; k++)
            send_item(CMD_LOAD, k == 0, base + k, pick_score(),
                      FREQ_W'($urandom_range(0, 16'hFFFF)));
        for (k = 0; k < 40; k++)
            send_item(CMD_PROBE, 1'b0, base + k, pick_score(), 16'd0);
        wait_drained();

        // ---- random merge rounds under each idling pattern ----
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 88;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct <= 21;
                end
            endcase
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target) begin
                // mostly short lists, now and then a longer one
                len = ($urandom_range(19) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 16);
                case ($urandom_range(3))
                    0:       base = '0;
                    1:       base = 32'hFFFF_FFFF - 3 * len;
                    default: base = $urandom_range(0, 32'hFFFF_FF00);
                endcase
                list_ids.delete();
                id = base;
                for (k = 0; k < len; k++) begin
                    // gap of zero gives a duplicate id
                    if (k != 0)
                        id = id + (($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3));
                    list_ids.insert(list_ids.size(), id);
                    // rare restart in the middle of a list
                    send_item(CMD_LOAD, (k == 0) || ($urandom_range(63) == 0), id,
                              pick_score(), FREQ_W'($urandom_range(0, 16'hFFFF)));
                end
                foreach (list_ids[j]) begin
                    r = $urandom_range(99);
                    if (r < 55) begin
                        // hit on the stored id
                        send_item(CMD_PROBE, 1'($urandom_range(1)), list_ids[j], pick_score(),
                                  FREQ_W'($urandom_range(0, 16'hFFFF)));
                    end else if (r < 72) begin
                        // just below, usually a miss
                        send_item(CMD_PROBE, 1'($urandom_range(1)), list_ids[j] - 1,
                                  pick_score(), FREQ_W'($urandom_range(0, 16'hFFFF)));
                    end else if (r < 84) begin
                        // entry skipped by the second list
                    end else if (r < 90) begin
                        // out of order probe
                        send_item(CMD_PROBE, 1'b0, list_ids[0], pick_score(), 16'd0);
                    end else if (r < 95) begin
                        // load in the middle of probing
                        send_item(CMD_LOAD, 1'b0, $urandom, pick_score(),
                                  FREQ_W'($urandom_range(0, 16'hFFFF)));
                    end else begin
                        // noise item
                        send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                                  $urandom, FREQ_W'($urandom_range(0, 16'hFFFF)));
                    end
                end
                // probe at or past the end of the list
                send_item(CMD_PROBE, 1'b0, list_ids[len - 1] + $urandom_range(1), pick_score(),
                          16'd0);
            end
            wait_drained();
        end

        // let any trailing walk finish before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
